>>> hdl/sru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sru_pkg
// Shared types and constants for the x86 shift/rotate unit.
// ----------------------------------------------------------------------------
package sru_pkg;

    localparam int OPER_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int CNT_IN_W = 8;
    localparam int CNT_W    = 5;
    localparam int CMD_W    = 3;

    // s_tdata: command, operand_value, shift_count, zero pad
    localparam int S_TDATA_W = 48;
    // m_tdata: result_value, write_enable, cf, of, of_write, sf, zf, pf,
    // arith_write, invalid_op, zero pad
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_SHL = 3'd0,
        CMD_SHR = 3'd1,
        CMD_SAR = 3'd2,
        CMD_ROL = 3'd3,
        CMD_ROR = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic                byte_size;
        logic [OPER_W-1:0]   operand_value;
        logic [CNT_IN_W-1:0] shift_count;
    } sru_req_t;

    typedef struct packed {
        logic [OPER_W-1:0] result_value;
        logic              write_enable;
        logic              carry_flag;
        logic              overflow_flag;
        logic              overflow_write;
        logic              sign_flag;
        logic              zero_flag;
        logic              parity_flag;
        logic              arith_flags_write;
        logic              invalid_op;
    } sru_rsp_t;

endpackage

>>> hdl/x86_shift_rotate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_shift_rotate_unit
// SHL/SHR/SAR/ROL/ROR on byte or 32-bit operands with x86 flag updates.
// ----------------------------------------------------------------------------
// The unit accepts one item every clock cycle while m_tready is high and
// returns one result item per input item, in order: an input register feeds
// a single barrel shifter with flag logic, whose output lands in a result
// register. Both stages advance independently, so a stalled result side
// still lets one more item be taken in; m_tready low for longer holds
// s_tready low. The count is masked to five bits; a zero count, or a byte
// rotate by a multiple of eight, writes nothing.
module x86_shift_rotate_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] command, [34:3] operand_value, [42:35] shift_count, [47:43] zero
    input  logic [sru_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] byte_size
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] result_value, [32] write_enable, [33] carry_flag,
    // [34] overflow_flag, [35] overflow_write, [36] sign_flag,
    // [37] zero_flag, [38] parity_flag, [39] arith_flags_write,
    // [40] invalid_op, [47:41] zero
    output logic [sru_pkg::M_TDATA_W-1:0]  m_tdata
);
    import sru_pkg::*;

    sru_req_t req_reg, req_next;
    sru_rsp_t rsp_reg, rsp_comb;
    logic     in_valid_reg, out_valid_reg;
    logic     out_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;

    always_comb begin
        req_next.command       = s_tdata[2:0];
        req_next.operand_value = s_tdata[34:3];
        req_next.shift_count   = s_tdata[42:35];
        req_next.byte_size     = s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg <= req_next;
        end
    end

    sru_core u_core (
        .req (req_reg),
        .rsp (rsp_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            rsp_reg <= rsp_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       rsp_reg.invalid_op,
                       rsp_reg.arith_flags_write,
                       rsp_reg.parity_flag,
                       rsp_reg.zero_flag,
                       rsp_reg.sign_flag,
                       rsp_reg.overflow_write,
                       rsp_reg.overflow_flag,
                       rsp_reg.carry_flag,
                       rsp_reg.write_enable,
                       rsp_reg.result_value};

endmodule

>>> hdl/sru_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sru_core
// Barrel shift/rotate datapath with x86 flag generation (combinational).
// ----------------------------------------------------------------------------
module sru_core (
    input  sru_pkg::sru_req_t req,
    output sru_pkg::sru_rsp_t rsp
);
    import sru_pkg::*;

    logic [CNT_W-1:0]    cnt;
    logic [OPER_W-1:0]   val;
    logic [BYTE_W-1:0]   v8;
    logic [OPER_W:0]     shl32, shr32, sar32;
    logic [2*OPER_W-1:0] rol32, ror32;
    logic [OPER_W:0]     shl8, shr8, sar8;
    logic [2*BYTE_W-1:0] rol8, ror8;
    logic [2:0]          rc8;
    logic [OPER_W-1:0]   res;
    logic                cf, of, msb, written, arith, known;

    assign cnt = req.shift_count[CNT_W-1:0];
    assign val = req.operand_value;
    assign v8  = val[BYTE_W-1:0];
    assign rc8 = cnt[2:0];

    assign shl32 = {1'b0, val} << cnt;
    assign shr32 = {val, 1'b0} >> cnt;
    assign sar32 = $unsigned($signed({val, 1'b0}) >>> cnt);
    assign rol32 = {val, val} << cnt;
    assign ror32 = {val, val} >> cnt;

    assign shl8 = {25'd0, v8} << cnt;
    assign shr8 = {24'd0, v8, 1'b0} >> cnt;
    assign sar8 = $unsigned($signed({{24{v8[BYTE_W-1]}}, v8, 1'b0}) >>> cnt);
    assign rol8 = {v8, v8} << rc8;
    assign ror8 = {v8, v8} >> rc8;

    always_comb begin
        res     = '0;
        cf      = 1'b0;
        of      = 1'b0;
        written = 1'b1;
        arith   = 1'b0;
        known   = 1'b1;
        case (req.command)
            CMD_SHL: begin
                arith = 1'b1;
                if (req.byte_size) begin
                    res = {24'd0, shl8[BYTE_W-1:0]};
                    cf  = shl8[BYTE_W];
                end else begin
                    res = shl32[OPER_W-1:0];
                    cf  = shl32[OPER_W];
                end
            end
            CMD_SHR: begin
                arith = 1'b1;
                if (req.byte_size) begin
                    res = {24'd0, shr8[BYTE_W:1]};
                    cf  = shr8[0];
                    of  = v8[BYTE_W-1];
                end else begin
                    res = shr32[OPER_W:1];
                    cf  = shr32[0];
                    of  = val[OPER_W-1];
                end
            end
            CMD_SAR: begin
                arith = 1'b1;
                if (req.byte_size) begin
                    res = {24'd0, sar8[BYTE_W:1]};
                    cf  = sar8[0];
                end else begin
                    res = sar32[OPER_W:1];
                    cf  = sar32[0];
                end
            end
            CMD_ROL: begin
                if (req.byte_size) begin
                    res     = {24'd0, rol8[2*BYTE_W-1:BYTE_W]};
                    written = (rc8 != 3'd0);
                end else begin
                    res = rol32[2*OPER_W-1:OPER_W];
                end
                cf = res[0];
            end
            CMD_ROR: begin
                if (req.byte_size) begin
                    res     = {24'd0, ror8[BYTE_W-1:0]};
                    written = (rc8 != 3'd0);
                    cf      = res[BYTE_W-1];
                    of      = res[BYTE_W-1] ^ res[BYTE_W-2];
                end else begin
                    res = ror32[OPER_W-1:0];
                    cf  = res[OPER_W-1];
                    of  = res[OPER_W-1] ^ res[OPER_W-2];
                end
            end
            default: begin
                known   = 1'b0;
                written = 1'b0;
            end
        endcase
    end

    assign msb = req.byte_size ? res[BYTE_W-1] : res[OPER_W-1];

    always_comb begin
        rsp = '0;
        if (cnt != '0) begin
            if (!known) begin
                rsp.invalid_op = 1'b1;
            end else if (written) begin
                rsp.result_value = res;
                rsp.write_enable = 1'b1;
                rsp.carry_flag   = cf;
                if (cnt == CNT_W'(1)) begin
                    rsp.overflow_write = 1'b1;
                    if (req.command == CMD_SHL || req.command == CMD_ROL) begin
                        rsp.overflow_flag = msb ^ cf;
                    end else begin
                        rsp.overflow_flag = of;
                    end
                end
                if (arith) begin
                    rsp.arith_flags_write = 1'b1;
                    rsp.sign_flag         = msb;
                    rsp.zero_flag         = (res == '0);
                    rsp.parity_flag       = ~^res[BYTE_W-1:0];
                end
            end
        end
    end

endmodule
